### rtl/rito_pkg.sv
// ----------------------------------------------------------------------------
// rito_pkg
// Shared constants, state encoding and control structs for the row id to
// row offset converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rito_pkg;

	localparam int ROWS        = 64;
	localparam int ID_BITS     = 12;
	localparam int POS_BITS    = 16;
	localparam int ROW_BITS    = 6;
	localparam int CNT_BITS    = 7;
	localparam int CFG_BITS    = 7;
	localparam int S_DATA_BITS = 16;
	localparam int M_DATA_BITS = 40;

	localparam logic [CNT_BITS-1:0] ROWS_C        = CNT_BITS'(ROWS);
	localparam logic [CFG_BITS-1:0] ROW_COUNT_RST = CFG_BITS'(64);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_OPEN_CLOSE,
		ST_FILL,
		ST_ADVANCE,
		ST_ALL_CLOSE,
		ST_ALL_FILL
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic accept;
		logic clear;
		logic emit_err;
		logic emit_open;
		logic emit_fill;
		logic tgt_rc;
		logic advance;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic stopped;
		logic is_open;
		logic in_ge;
		logic in_lt_open;
		logic in_eq_open;
		logic in_last;
		logic in_empty;
		logic last_q;
		logic fill_more;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

### rtl/rito_ctrl.sv
// ----------------------------------------------------------------------------
// rito_ctrl
// Sequencer that walks one item through its result phases: error, closing
// the open row, filling skipped rows, opening the new row and closing all.
// ----------------------------------------------------------------------------
`default_nettype none

module rito_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	input  wire rito_pkg::stat_t stat,
	output rito_pkg::cmd_t       cmd
);

	rito_pkg::state_t state_q;
	rito_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rito_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rito_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (stat.stopped) begin
						state_d = rito_pkg::ST_IDLE;
					end else if (stat.in_empty || stat.in_ge) begin
						state_d = rito_pkg::ST_ALL_CLOSE;
					end else if (stat.in_lt_open) begin
						state_d = rito_pkg::ST_ERR;
					end else if (stat.in_eq_open) begin
						state_d = rito_pkg::ST_ADVANCE;
					end else if (stat.is_open) begin
						state_d = rito_pkg::ST_OPEN_CLOSE;
					end else begin
						state_d = rito_pkg::ST_FILL;
					end
				end
			end
			rito_pkg::ST_ERR: begin
				if (stat.out_free) begin
					state_d = stat.last_q ? rito_pkg::ST_ALL_CLOSE : rito_pkg::ST_IDLE;
				end
			end
			rito_pkg::ST_OPEN_CLOSE: begin
				if (stat.out_free) begin
					state_d = rito_pkg::ST_FILL;
				end
			end
			rito_pkg::ST_FILL: begin
				if (!stat.fill_more) begin
					state_d = rito_pkg::ST_ADVANCE;
				end
			end
			rito_pkg::ST_ADVANCE: begin
				state_d = stat.last_q ? rito_pkg::ST_ALL_CLOSE : rito_pkg::ST_IDLE;
			end
			rito_pkg::ST_ALL_CLOSE: begin
				if (!stat.is_open || stat.out_free) begin
					state_d = rito_pkg::ST_ALL_FILL;
				end
			end
			rito_pkg::ST_ALL_FILL: begin
				if (!stat.fill_more) begin
					state_d = rito_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rito_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			rito_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.accept   = s_tvalid;
				cmd.clear    = s_tvalid && stat.stopped && (stat.in_last || stat.in_empty);
			end
			rito_pkg::ST_ERR: begin
				cmd.emit_err = stat.out_free;
			end
			rito_pkg::ST_OPEN_CLOSE: begin
				cmd.emit_open = stat.out_free;
			end
			rito_pkg::ST_FILL: begin
				cmd.emit_fill = stat.fill_more && stat.out_free;
			end
			rito_pkg::ST_ADVANCE: begin
				cmd.advance = 1'b1;
			end
			rito_pkg::ST_ALL_CLOSE: begin
				cmd.tgt_rc    = 1'b1;
				cmd.emit_open = stat.is_open && stat.out_free;
			end
			rito_pkg::ST_ALL_FILL: begin
				cmd.tgt_rc    = 1'b1;
				cmd.emit_fill = stat.fill_more && stat.out_free;
				cmd.finish    = !stat.fill_more;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/rito_dp.sv
// ----------------------------------------------------------------------------
// rito_dp
// Stream state, row count register, row compares and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rito_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rito_pkg::cmd_t                      cmd,
	output rito_pkg::stat_t                          stat,
	input  wire logic [rito_pkg::S_DATA_BITS-1:0]    s_tdata,   // row_id, zero pad
	input  wire logic                                s_tlast,
	input  wire logic [0:0]                          s_tuser,   // empty_req
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [rito_pkg::M_DATA_BITS-1:0]    m_tdata,   // row, begin_res, finish, pad
	output logic                                     m_tlast,
	output logic      [0:0]                          m_tuser,   // error
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rito_pkg::CFG_BITS-1:0]       cfg_data
);

	localparam int IB = rito_pkg::ID_BITS;
	localparam int PB = rito_pkg::POS_BITS;
	localparam int RB = rito_pkg::ROW_BITS;
	localparam int CB = rito_pkg::CNT_BITS;

	logic [rito_pkg::CFG_BITS-1:0] row_count_q;
	logic [CB-1:0]                 next_row_q;
	logic [RB-1:0]                 open_row_q;
	logic                          open_q;
	logic [PB-1:0]                 open_begin_q;
	logic [PB-1:0]                 pos_q;
	logic                          stopped_q;
	logic                          out_valid_q;

	logic [IB-1:0] id_q;
	logic          last_q;
	logic          stop_q;

	logic [RB-1:0] out_row_q;
	logic [PB-1:0] out_begin_q;
	logic [PB-1:0] out_finish_q;
	logic          out_last_q;
	logic          out_err_q;

	logic [CB-1:0] eff_rows;
	logic [IB-1:0] in_id;
	logic          in_ge;
	logic [CB-1:0] tgt;
	logic          tail_more;
	logic [CB-1:0] open_next;
	logic [CB-1:0] fill_next;
	logic          out_free;
	logic          same_row;

	assign eff_rows  = (CB'(row_count_q) < rito_pkg::ROWS_C) ? CB'(row_count_q) : rito_pkg::ROWS_C;
	assign in_id     = s_tdata[IB-1:0];
	assign in_ge     = in_id >= IB'(eff_rows);
	assign tgt       = cmd.tgt_rc ? eff_rows : id_q[CB-1:0];
	assign tail_more = !cmd.tgt_rc && last_q;
	assign open_next = CB'(open_row_q) + CB'(1);
	assign fill_next = next_row_q + CB'(1);
	assign out_free  = !out_valid_q || m_tready;
	assign same_row  = open_q && (id_q == IB'(open_row_q));

	always_comb begin
		stat            = '0;
		stat.stopped    = stopped_q;
		stat.is_open    = open_q;
		stat.in_ge      = in_ge;
		stat.in_lt_open = open_q && (in_id < IB'(open_row_q));
		stat.in_eq_open = open_q && (in_id == IB'(open_row_q));
		stat.in_last    = s_tlast;
		stat.in_empty   = s_tuser[0];
		stat.last_q     = last_q;
		stat.fill_more  = next_row_q < tgt;
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= rito_pkg::ROW_COUNT_RST;
			next_row_q   <= '0;
			open_row_q   <= '0;
			open_q       <= 1'b0;
			open_begin_q <= '0;
			pos_q        <= '0;
			stopped_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				row_count_q <= cfg_data;
			end
			if (cmd.emit_err || cmd.emit_open || cmd.emit_fill) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clear || (cmd.finish && !stop_q)) begin
				next_row_q   <= '0;
				open_row_q   <= '0;
				open_q       <= 1'b0;
				open_begin_q <= '0;
				pos_q        <= '0;
				stopped_q    <= 1'b0;
			end else if (cmd.finish) begin
				stopped_q <= 1'b1;
			end else if (cmd.emit_open) begin
				next_row_q <= open_next;
				open_q     <= 1'b0;
			end else if (cmd.emit_fill) begin
				next_row_q <= fill_next;
			end else if (cmd.advance) begin
				if (!same_row) begin
					open_row_q   <= id_q[RB-1:0];
					open_begin_q <= pos_q;
					open_q       <= 1'b1;
					next_row_q   <= id_q[CB-1:0];
				end
				if (pos_q != {PB{1'b1}}) begin
					pos_q <= pos_q + PB'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			id_q   <= in_id;
			last_q <= s_tlast;
			stop_q <= !s_tuser[0] && in_ge && !s_tlast;
		end
		if (cmd.emit_err) begin
			out_row_q    <= '0;
			out_begin_q  <= '0;
			out_finish_q <= '0;
			out_last_q   <= !last_q;
			out_err_q    <= 1'b1;
		end else if (cmd.emit_open) begin
			out_row_q    <= open_row_q;
			out_begin_q  <= open_begin_q;
			out_finish_q <= pos_q;
			out_last_q   <= !((open_next < tgt) || tail_more);
			out_err_q    <= 1'b0;
		end else if (cmd.emit_fill) begin
			out_row_q    <= next_row_q[RB-1:0];
			out_begin_q  <= pos_q;
			out_finish_q <= pos_q;
			out_last_q   <= !((fill_next < tgt) || tail_more);
			out_err_q    <= 1'b0;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(rito_pkg::M_DATA_BITS - RB - 2 * PB){1'b0}},
		out_finish_q, out_begin_q, out_row_q};
	assign m_tlast   = out_last_q;
	assign m_tuser   = out_err_q;

`ifndef ASSERT_OFF
	a_stop_closed: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !open_q)
		else $error("stopped stream still has an open row");
	a_open_next: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (next_row_q == CB'(open_row_q)))
		else $error("next row out of step with open row");
	a_next_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_row_q <= rito_pkg::ROWS_C)
		else $error("next row beyond row limit");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (m_tdata == '0))
		else $error("error item carries offsets");
`endif

endmodule

`default_nettype wire

### rtl/row_ids_to_row_offsets.sv
// Throughput: one result per cycle from the sequencer while the output is free; a new item
//   is accepted only in the idle state, once the previous item has gone through its phases,
//   and the row fill counter steps one row per fill result.
// Reset: asynchronous, active low; clears stream state and sets row_count to 64.
// ----------------------------------------------------------------------------
// row_ids_to_row_offsets
// Converts a nondecreasing row id stream into per-row begin and finish
// element positions, one result item per output row.
// ----------------------------------------------------------------------------
`default_nettype none

module row_ids_to_row_offsets (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [rito_pkg::S_DATA_BITS-1:0] s_tdata,   // row_id, zero pad
	input  wire logic                             s_tlast,
	input  wire logic [0:0]                       s_tuser,   // empty_req
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [rito_pkg::M_DATA_BITS-1:0] m_tdata,   // row, begin_res, finish, pad
	output logic                                  m_tlast,
	output logic      [0:0]                       m_tuser,   // error
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rito_pkg::CFG_BITS-1:0]    cfg_data
);

	rito_pkg::cmd_t  cmd;
	rito_pkg::stat_t stat;

	rito_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	rito_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	assign s_tready = cmd.in_ready;

endmodule

`default_nettype wire
